FILE: hw/rtl/meo_pkg.sv
// ----------------------------------------------------------------------------
// meo_pkg: shared types for the midpoint ellipse outline core
// Command and status records between controller and datapath, operation
// codes of the input word and the fixed dot pattern offsets.
// ----------------------------------------------------------------------------
package meo_pkg;

    // default coordinate width
    localparam int MEO_COORD_W = 12;

    // operation codes of an input word
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // index of the final pixel of the dot pattern
    localparam int DOT_LAST = 11;

    // register update selected by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SET_RX2,
        DP_SET_RY2,
        DP_INIT_D,
        DP_STEP,
        DP_KEEP_P1,
        DP_UPDATE,
        DP_TMP,
        DP_D_PROD,
        DP_D_ADD4,
        DP_D_SUB4,
        DP_WALK
    } t_dp_op;

    // operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SQ_H,
        MUL_SQ_V,
        MUL_RX2_RV,
        MUL_RY2_NX,
        MUL_RX2_NY,
        MUL_TT,
        MUL_SS,
        MUL_RY2_TMP,
        MUL_RX2_TMP,
        MUL_RX2_RY2
    } t_mul_op;

    // pixel source for the output word
    typedef enum logic [2:0] {
        PIX_NONE,
        PIX_PP,
        PIX_MP,
        PIX_PM,
        PIX_MM,
        PIX_HRUN,
        PIX_VRUN,
        PIX_DOT
    } t_pix_sel;

    // run index update
    typedef enum logic [1:0] {
        RUN_HOLD,
        RUN_INC,
        RUN_CLR
    } t_run_op;

    typedef struct packed {
        t_dp_op   op;
        t_mul_op  mul;
        logic     reg2;
        logic     emit;
        t_pix_sel pix;
        logic     last;
        logic     done;
        t_run_op  run;
    } t_dp_cmd;

    typedef struct packed {
        logic rad_neg;
        logic rad_zero;
        logic rad_dot;
        logic term;
        logic ny_neg;
        logic run_end_h;
        logic run_end_v;
        logic dot_end;
        logic out_free;
    } t_dp_sts;

    // column offset of dot pattern pixel idx
    function automatic logic signed [2:0] dot_dx(input logic [3:0] idx);
        logic signed [2:0] v;
        unique case (idx)
            4'd0, 4'd3:                v = -3'sd1;
            4'd1, 4'd4:                v = 3'sd0;
            4'd2, 4'd5:                v = 3'sd1;
            4'd6, 4'd8, 4'd10:         v = -3'sd2;
            4'd7, 4'd9, 4'd11:         v = 3'sd2;
            default:                   v = 3'sd0;
        endcase
        return v;
    endfunction

    // row offset of dot pattern pixel idx
    function automatic logic signed [2:0] dot_dy(input logic [3:0] idx);
        logic signed [2:0] v;
        unique case (idx)
            4'd0, 4'd1, 4'd2:          v = -3'sd2;
            4'd3, 4'd4, 4'd5:          v = 3'sd2;
            4'd6, 4'd7:                v = -3'sd1;
            4'd8, 4'd9:                v = 3'sd0;
            4'd10, 4'd11:              v = 3'sd1;
            default:                   v = 3'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/midpoint_ellipse_outline_core.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_outline_core: ellipse outline pixel generator
// Start words load a figure; advance words yield its next outline pixels.
// ----------------------------------------------------------------------------
// Usage
//   Input channel i_valid / o_stall: a start word (operation 0) loads centre,
//   radii and color and yields no output; an advance word (operation 1)
//   yields one or four output words, the final one flagged last_of_step.
//   Output channel o_valid / i_stall carries one pixel word per handshake.
// Sequencing (one word in flight at a time, o_stall high while busy)
//   Start: run, dot and empty figures are classified and done; an ellipse
//   also forms two radius squares and one product on the shared multiplier.
//   Advance on a run or dot: one pixel word.
//   Advance on an ellipse step: two products and the decision update, then
//   four pixel words; the step that enters the second region also seeds the
//   decision term on the shared multiplier before its pixel words.
// Stall: a held output word stays put; pending words wait in the sequencer
//   and the next input word is taken while the last output word waits.
// Reset: figure marked finished, output register empty; no clearing pass.
// ----------------------------------------------------------------------------
module midpoint_ellipse_outline_core #(
    parameter int COORD_WIDTH = meo_pkg::MEO_COORD_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_radius_x,
    input  logic signed [COORD_WIDTH-1:0] i_radius_y,
    input  logic [15:0]                   i_color,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH:0]   o_pixel_x,
    output logic signed [COORD_WIDTH:0]   o_pixel_y,
    output logic [15:0]                   o_pixel_color,
    output logic                          o_pixel_valid,
    output logic                          o_last_of_step,
    output logic                          o_figure_done
);
    import meo_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    meo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and output word
    meo_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius_x     (i_radius_x),
        .i_radius_y     (i_radius_y),
        .i_color        (i_color),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_pixel_valid  (o_pixel_valid),
        .o_last_of_step (o_last_of_step),
        .o_figure_done  (o_figure_done)
    );

endmodule

FILE: hw/rtl/meo_datapath.sv
// ----------------------------------------------------------------------------
// meo_datapath: arithmetic and output register of the ellipse core
// Holds figure geometry, walk position, decision term, a shared registered
// multiplier and the output word. Driven by commands from meo_ctrl.
// ----------------------------------------------------------------------------
module meo_datapath #(
    parameter int COORD_WIDTH = meo_pkg::MEO_COORD_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  meo_pkg::t_dp_cmd              i_cmd,
    output meo_pkg::t_dp_sts              o_sts,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_radius_x,
    input  logic signed [COORD_WIDTH-1:0] i_radius_y,
    input  logic [15:0]                   i_color,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH:0]   o_pixel_x,
    output logic signed [COORD_WIDTH:0]   o_pixel_y,
    output logic [15:0]                   o_pixel_color,
    output logic                          o_pixel_valid,
    output logic                          o_last_of_step,
    output logic                          o_figure_done
);
    import meo_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int PW  = W + 1;          // pixel and walk width
    localparam int SQW = 2 * W;          // squared radius
    localparam int MA  = 2 * W + 1;      // multiplier operand a
    localparam int MB  = 2 * W + 3;      // multiplier operand b
    localparam int DW  = MA + MB;        // decision and product width
    localparam logic signed [W-1:0]  DOT_RAD = W'(2);
    localparam logic signed [DW-1:0] D_ZERO  = '0;

    // figure geometry
    logic signed [W-1:0]   r_cx, r_cy, r_rh, r_rv;
    logic [15:0]           r_color;
    logic [SQW-1:0]        r_rx2, r_ry2;
    // walk position and next position
    logic signed [PW-1:0]  r_wx, r_wy, r_nx, r_ny;
    logic                  r_dflag;
    logic [PW-1:0]         r_run;
    // decision term and multiplier results
    logic signed [DW-1:0]  r_d, r_p1, r_prod;
    logic signed [MB-1:0]  r_tmp;
    // output word
    logic                  r_out_valid;
    logic signed [PW-1:0]  r_o_x, r_o_y;
    logic [15:0]           r_o_color;
    logic                  r_o_pv, r_o_last, r_o_done;

    logic signed [MA-1:0]  rx2_s, ry2_s, t_val, s_val, mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [DW-1:0]  mul_p, rx2_d, ry2_d, sq_x4, p1_x8, p2_x8, d_upd, d_init;
    logic signed [DW-1:0]  cmp_rhs;
    logic                  add_p1, sub_p2, d_neg, d_pos;
    logic signed [PW-1:0]  wx_inc, wy_dec, cx_e, cy_e, rh_e, rv_e, run_s;
    logic signed [PW-1:0]  pix_x, pix_y;

    assign rx2_s = $signed({1'b0, r_rx2});
    assign ry2_s = $signed({1'b0, r_ry2});
    assign rx2_d = DW'(rx2_s);
    assign ry2_d = DW'(ry2_s);
    assign t_val = MA'(r_nx) + MA'(r_nx) + MA'(1);
    assign s_val = MA'(r_ny) - MA'(1);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.mul)
            MUL_NONE:    ;
            MUL_SQ_H:    begin mul_a = MA'(r_rh);  mul_b = MB'(r_rh);  end
            MUL_SQ_V:    begin mul_a = MA'(r_rv);  mul_b = MB'(r_rv);  end
            MUL_RX2_RV:  begin mul_a = rx2_s;      mul_b = MB'(r_rv);  end
            MUL_RY2_NX:  begin mul_a = ry2_s;      mul_b = MB'(r_nx);  end
            MUL_RX2_NY:  begin mul_a = rx2_s;      mul_b = MB'(r_ny);  end
            MUL_TT:      begin mul_a = t_val;      mul_b = MB'(t_val); end
            MUL_SS:      begin mul_a = s_val;      mul_b = MB'(s_val); end
            MUL_RY2_TMP: begin mul_a = ry2_s;      mul_b = r_tmp;      end
            MUL_RX2_TMP: begin mul_a = rx2_s;      mul_b = r_tmp;      end
            MUL_RX2_RY2: begin mul_a = rx2_s;      mul_b = MB'(ry2_s); end
            default:     ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // step arithmetic
    assign wx_inc = r_wx + PW'(1);
    assign wy_dec = r_wy - PW'(1);
    assign d_neg  = r_d[DW-1];
    assign d_pos  = !d_neg && (r_d != D_ZERO);

    // decision update: region 1 steps x, region 2 steps y
    assign add_p1 = i_cmd.reg2 ? !r_dflag : 1'b1;
    assign sub_p2 = i_cmd.reg2 ? 1'b1 : !r_dflag;
    assign p1_x8  = r_p1 <<< 3;
    assign p2_x8  = r_prod <<< 3;
    assign sq_x4  = (i_cmd.reg2 ? rx2_d : ry2_d) <<< 2;
    assign d_upd  = r_d + (add_p1 ? p1_x8 : D_ZERO) - (sub_p2 ? p2_x8 : D_ZERO) + sq_x4;
    assign d_init = (ry2_d <<< 2) - (r_prod <<< 2) + rx2_d;

    // region 1 ends once ry2*x reaches rx2*max(y,0)
    assign cmp_rhs = r_ny[PW-1] ? D_ZERO : r_prod;

    // pixel position select
    assign cx_e  = PW'(r_cx);
    assign cy_e  = PW'(r_cy);
    assign rh_e  = PW'(r_rh);
    assign rv_e  = PW'(r_rv);
    assign run_s = $signed(r_run);

    always_comb begin
        pix_x = '0;
        pix_y = '0;
        unique case (i_cmd.pix)
            PIX_NONE: ;
            PIX_PP:   begin pix_x = cx_e + r_wx; pix_y = cy_e + r_wy; end
            PIX_MP:   begin pix_x = cx_e - r_wx; pix_y = cy_e + r_wy; end
            PIX_PM:   begin pix_x = cx_e + r_wx; pix_y = cy_e - r_wy; end
            PIX_MM:   begin pix_x = cx_e - r_wx; pix_y = cy_e - r_wy; end
            PIX_HRUN: begin pix_x = cx_e - rh_e + run_s; pix_y = cy_e; end
            PIX_VRUN: begin pix_x = cx_e; pix_y = cy_e - rv_e + run_s; end
            PIX_DOT:  begin
                pix_x = cx_e + PW'(dot_dx(r_run[3:0]));
                pix_y = cy_e + PW'(dot_dy(r_run[3:0]));
            end
            default:  ;
        endcase
    end

    // geometry, walk and decision registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (i_cmd.op)
            DP_NOP:     ;
            DP_LOAD:    begin
                r_cx    <= i_center_x;
                r_cy    <= i_center_y;
                r_rh    <= i_radius_x;
                r_rv    <= i_radius_y;
                r_color <= i_color;
                r_wx    <= '0;
                r_wy    <= PW'(i_radius_y);
                r_d     <= D_ZERO;
            end
            DP_SET_RX2: r_rx2 <= r_prod[SQW-1:0];
            DP_SET_RY2: r_ry2 <= r_prod[SQW-1:0];
            DP_INIT_D:  r_d   <= d_init;
            DP_STEP:    begin
                if (i_cmd.reg2) begin
                    r_ny    <= wy_dec;
                    r_dflag <= d_pos;
                    r_nx    <= d_pos ? r_wx : wx_inc;
                end else begin
                    r_nx    <= wx_inc;
                    r_dflag <= d_neg;
                    r_ny    <= d_neg ? r_wy : wy_dec;
                end
            end
            DP_KEEP_P1: r_p1  <= r_prod;
            DP_UPDATE:  r_d   <= d_upd;
            DP_TMP:     r_tmp <= r_prod[MB-1:0];
            DP_D_PROD:  r_d   <= r_prod;
            DP_D_ADD4:  r_d   <= r_d + (r_prod <<< 2);
            DP_D_SUB4:  r_d   <= r_d - (r_prod <<< 2);
            DP_WALK:    begin
                r_wx <= r_nx;
                r_wy <= r_ny;
            end
            default:    ;
        endcase

        // run index
        if (i_cmd.op == DP_LOAD) begin
            r_run <= '0;
        end else begin
            unique case (i_cmd.run)
                RUN_HOLD: ;
                RUN_INC:  r_run <= r_run + PW'(1);
                RUN_CLR:  r_run <= '0;
                default:  ;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_x     <= pix_x;
            r_o_y     <= pix_y;
            r_o_pv    <= (i_cmd.pix != PIX_NONE);
            r_o_color <= (i_cmd.pix != PIX_NONE) ? r_color : 16'h0000;
            r_o_last  <= i_cmd.last;
            r_o_done  <= i_cmd.done;
        end
    end

    // status to controller
    assign o_sts.rad_neg   = r_rh[W-1] | r_rv[W-1];
    assign o_sts.rad_zero  = (r_rh == '0) || (r_rv == '0);
    assign o_sts.rad_dot   = (r_rh == DOT_RAD) && (r_rv == DOT_RAD);
    assign o_sts.term      = !(r_p1 < cmp_rhs);
    assign o_sts.ny_neg    = r_ny[PW-1];
    assign o_sts.run_end_h = r_run >= {r_rh, 1'b0};
    assign o_sts.run_end_v = r_run >= {r_rv, 1'b0};
    assign o_sts.dot_end   = r_run >= PW'(DOT_LAST);
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_o_x;
    assign o_pixel_y      = r_o_y;
    assign o_pixel_color  = r_o_color;
    assign o_pixel_valid  = r_o_pv;
    assign o_last_of_step = r_o_last;
    assign o_figure_done  = r_o_done;

endmodule

FILE: hw/rtl/meo_ctrl.sv
// ----------------------------------------------------------------------------
// meo_ctrl: sequencer of the ellipse core
// Tracks the figure phase, accepts input words and steps the datapath
// through setup, midpoint update and pixel output.
// ----------------------------------------------------------------------------
module meo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_operation,
    output logic             o_stall,
    input  meo_pkg::t_dp_sts i_sts,
    output meo_pkg::t_dp_cmd o_cmd
);
    import meo_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_SQ_V,
        S_INIT_M,
        S_INIT_D,
        S_STEP_B,
        S_STEP_C,
        S_STEP_D,
        S_T1,
        S_T2,
        S_T3,
        S_T4,
        S_T5,
        S_T6,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_HRUN,
        PH_VRUN,
        PH_DOT,
        PH_REG1,
        PH_REG2
    } t_phase;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [1:0] r_pix, n_pix;
    logic       r_quad, n_quad;
    t_dp_cmd    cmd;

    // state, phase and pixel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_DONE;
            r_pix   <= '0;
            r_quad  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pix   <= n_pix;
            r_quad  <= n_quad;
        end
    end

    // next state and datapath command
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_pix    = r_pix;
        n_quad   = r_quad;
        cmd.op   = DP_NOP;
        cmd.mul  = MUL_NONE;
        cmd.reg2 = (r_phase == PH_REG2);
        cmd.emit = 1'b0;
        cmd.pix  = PIX_NONE;
        cmd.last = 1'b0;
        cmd.done = 1'b0;
        cmd.run  = RUN_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == OP_START) begin
                        cmd.op  = DP_LOAD;
                        n_state = S_CLASS;
                    end else if (r_phase == PH_REG1 || r_phase == PH_REG2) begin
                        cmd.op  = DP_STEP;
                        n_quad  = 1'b1;
                        n_pix   = '0;
                        n_state = S_STEP_B;
                    end else begin
                        n_quad  = 1'b0;
                        n_state = S_EMIT;
                    end
                end
            end
            // pick the figure kind from the loaded radii
            S_CLASS: begin
                cmd.mul = MUL_SQ_H;
                priority if (i_sts.rad_neg) begin
                    n_phase = PH_DONE;
                    n_state = S_IDLE;
                end else if (i_sts.rad_zero) begin
                    n_phase = PH_HRUN;
                    n_state = S_IDLE;
                end else if (i_sts.rad_dot) begin
                    n_phase = PH_DOT;
                    n_state = S_IDLE;
                end else begin
                    n_phase = PH_REG1;
                    n_state = S_SQ_V;
                end
            end
            S_SQ_V: begin
                cmd.op  = DP_SET_RX2;
                cmd.mul = MUL_SQ_V;
                n_state = S_INIT_M;
            end
            S_INIT_M: begin
                cmd.op  = DP_SET_RY2;
                cmd.mul = MUL_RX2_RV;
                n_state = S_INIT_D;
            end
            S_INIT_D: begin
                cmd.op  = DP_INIT_D;
                n_state = S_IDLE;
            end
            // midpoint update: two products, then the add
            S_STEP_B: begin
                cmd.mul = MUL_RY2_NX;
                n_state = S_STEP_C;
            end
            S_STEP_C: begin
                cmd.op  = DP_KEEP_P1;
                cmd.mul = MUL_RX2_NY;
                n_state = S_STEP_D;
            end
            S_STEP_D: begin
                cmd.op = DP_UPDATE;
                if (r_phase == PH_REG1) begin
                    n_state = i_sts.term ? S_T1 : S_EMIT;
                end else begin
                    if (i_sts.ny_neg) begin
                        n_phase = PH_DONE;
                    end
                    n_state = S_EMIT;
                end
            end
            // region 2 decision seed
            S_T1: begin
                cmd.mul = MUL_TT;
                n_state = S_T2;
            end
            S_T2: begin
                cmd.op  = DP_TMP;
                cmd.mul = MUL_SS;
                n_state = S_T3;
            end
            S_T3: begin
                cmd.op  = DP_TMP;
                cmd.mul = MUL_RY2_TMP;
                n_state = S_T4;
            end
            S_T4: begin
                cmd.op  = DP_D_PROD;
                cmd.mul = MUL_RX2_TMP;
                n_state = S_T5;
            end
            S_T5: begin
                cmd.op  = DP_D_ADD4;
                cmd.mul = MUL_RX2_RY2;
                n_state = S_T6;
            end
            S_T6: begin
                cmd.op  = DP_D_SUB4;
                n_phase = i_sts.ny_neg ? PH_DONE : PH_REG2;
                n_state = S_EMIT;
            end
            // hand words to the output register as it frees up
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (r_quad) begin
                        unique case (r_pix)
                            2'd0:    cmd.pix = PIX_PP;
                            2'd1:    cmd.pix = PIX_MP;
                            2'd2:    cmd.pix = PIX_PM;
                            default: cmd.pix = PIX_MM;
                        endcase
                        if (r_pix == 2'd3) begin
                            cmd.last = 1'b1;
                            cmd.done = (r_phase == PH_DONE);
                            cmd.op   = DP_WALK;
                            n_state  = S_IDLE;
                        end else begin
                            n_pix = r_pix + 2'd1;
                        end
                    end else begin
                        cmd.last = 1'b1;
                        n_state  = S_IDLE;
                        unique case (r_phase)
                            PH_HRUN: begin
                                cmd.pix = PIX_HRUN;
                                if (i_sts.run_end_h) begin
                                    cmd.run = RUN_CLR;
                                    n_phase = PH_VRUN;
                                end else begin
                                    cmd.run = RUN_INC;
                                end
                            end
                            PH_VRUN: begin
                                cmd.pix  = PIX_VRUN;
                                cmd.done = i_sts.run_end_v;
                                if (i_sts.run_end_v) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    cmd.run = RUN_INC;
                                end
                            end
                            PH_DOT: begin
                                cmd.pix  = PIX_DOT;
                                cmd.done = i_sts.dot_end;
                                if (i_sts.dot_end) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    cmd.run = RUN_INC;
                                end
                            end
                            default: begin
                                // finished figure: empty word
                                cmd.pix  = PIX_NONE;
                                cmd.done = 1'b1;
                                n_phase  = PH_DONE;
                            end
                        endcase
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;

endmodule

FILE: hw/rtl/meo_checker.sv
// ----------------------------------------------------------------------------
// meo_checker: port level checks of the ellipse core
// Watches the handshakes and output flags of the top level.
// ----------------------------------------------------------------------------
module meo_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_pixel_valid,
    input logic o_last_of_step,
    input logic o_figure_done
);

    // a stalled output word is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word dropped under stall");

    // each accepted word makes the block busy in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken back to back");

    // an empty word only reports a finished figure
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_valid |-> o_last_of_step && o_figure_done)
        else $error("empty word without done");

    // figure done only on the final word of a step
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_figure_done |-> o_last_of_step)
        else $error("done flagged mid step");

endmodule

bind midpoint_ellipse_outline_core meo_checker u_meo_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pixel_valid  (o_pixel_valid),
    .o_last_of_step (o_last_of_step),
    .o_figure_done  (o_figure_done)
);
